[design/shs_pkg.sv]
package shs_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int BLOCK_BYTES = 64;
   localparam int LEN_FILL = 56;
   localparam logic [7:0] PAD_MARK = 8'h80;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word_0;
      logic [31:0] digest_word_1;
      logic [31:0] digest_word_2;
      logic [31:0] digest_word_3;
      logic [31:0] digest_word_4;
      logic [31:0] digest_word_5;
      logic [31:0] digest_word_6;
      logic [31:0] digest_word_7;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic init;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } core_sts_type;

   typedef enum logic [1:0] {
      CORE_IDLE,
      CORE_RUN,
      CORE_FIN
   } core_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_COMP,
      ST_OUT
   } back_state_type;

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] val;
      unique case (idx)
         3'd0: val = 32'h6a09e667;
         3'd1: val = 32'hbb67ae85;
         3'd2: val = 32'h3c6ef372;
         3'd3: val = 32'ha54ff53a;
         3'd4: val = 32'h510e527f;
         3'd5: val = 32'h9b05688c;
         3'd6: val = 32'h1f83d9ab;
         default: val = 32'h5be0cd19;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] val;
      unique case (t)
         6'd0: val = 32'h428a2f98;  6'd1: val = 32'h71374491;
         6'd2: val = 32'hb5c0fbcf;  6'd3: val = 32'he9b5dba5;
         6'd4: val = 32'h3956c25b;  6'd5: val = 32'h59f111f1;
         6'd6: val = 32'h923f82a4;  6'd7: val = 32'hab1c5ed5;
         6'd8: val = 32'hd807aa98;  6'd9: val = 32'h12835b01;
         6'd10: val = 32'h243185be; 6'd11: val = 32'h550c7dc3;
         6'd12: val = 32'h72be5d74; 6'd13: val = 32'h80deb1fe;
         6'd14: val = 32'h9bdc06a7; 6'd15: val = 32'hc19bf174;
         6'd16: val = 32'he49b69c1; 6'd17: val = 32'hefbe4786;
         6'd18: val = 32'h0fc19dc6; 6'd19: val = 32'h240ca1cc;
         6'd20: val = 32'h2de92c6f; 6'd21: val = 32'h4a7484aa;
         6'd22: val = 32'h5cb0a9dc; 6'd23: val = 32'h76f988da;
         6'd24: val = 32'h983e5152; 6'd25: val = 32'ha831c66d;
         6'd26: val = 32'hb00327c8; 6'd27: val = 32'hbf597fc7;
         6'd28: val = 32'hc6e00bf3; 6'd29: val = 32'hd5a79147;
         6'd30: val = 32'h06ca6351; 6'd31: val = 32'h14292967;
         6'd32: val = 32'h27b70a85; 6'd33: val = 32'h2e1b2138;
         6'd34: val = 32'h4d2c6dfc; 6'd35: val = 32'h53380d13;
         6'd36: val = 32'h650a7354; 6'd37: val = 32'h766a0abb;
         6'd38: val = 32'h81c2c92e; 6'd39: val = 32'h92722c85;
         6'd40: val = 32'ha2bfe8a1; 6'd41: val = 32'ha81a664b;
         6'd42: val = 32'hc24b8b70; 6'd43: val = 32'hc76c51a3;
         6'd44: val = 32'hd192e819; 6'd45: val = 32'hd6990624;
         6'd46: val = 32'hf40e3585; 6'd47: val = 32'h106aa070;
         6'd48: val = 32'h19a4c116; 6'd49: val = 32'h1e376c08;
         6'd50: val = 32'h2748774c; 6'd51: val = 32'h34b0bcb5;
         6'd52: val = 32'h391c0cb3; 6'd53: val = 32'h4ed8aa4a;
         6'd54: val = 32'h5b9cca4f; 6'd55: val = 32'h682e6ff3;
         6'd56: val = 32'h748f82ee; 6'd57: val = 32'h78a5636f;
         6'd58: val = 32'h84c87814; 6'd59: val = 32'h8cc70208;
         6'd60: val = 32'h90befffa; 6'd61: val = 32'ha4506ceb;
         6'd62: val = 32'hbef9a3f7;
         default: val = 32'hc67178f2;
      endcase
      return val;
   endfunction

   function automatic logic [31:0] ror(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

[design/sha256_stream_hasher.sv]
// sha-256 of a byte stream, one byte per transfer; a transfer with last_byte
// closes the message (byte_valid low allows an empty one) and one digest
// transfer follows. bytes enter a small queue and are absorbed at one per
// cycle except while a block compresses or a message finishes; every 64
// bytes the round engine runs 64 rounds at one per cycle between a setup
// step and a chain update; this single engine paces a long message. finishing
// pads byte by byte with one or two more compressions. the digest sits
// in an output register, so the next message can start while it waits.
module sha256_stream_hasher #(
   parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shs_pkg::rsp_type rsp_data
);

   // queue between intake and hashing
   logic             q_valid;
   logic             q_pop;
   shs_pkg::req_type q_data;

   // intake side: buffers transfers, drops idle ones
   shs_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop)
   );

   // hashing side: block assembly, padding, rounds, digest register
   shs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   // never pop an empty queue
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   // no digest right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("digest valid after reset");
   // a digest is never raised directly on a pop
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(q_pop))
      else $error("digest raised directly on a pop");
`endif

endmodule

[design/shs_front.sv]
module shs_front #(
   parameter int QUEUE_DEPTH = shs_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shs_pkg::req_type req_data,
   output logic             q_valid,
   output shs_pkg::req_type q_data,
   input  logic             q_pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   shs_pkg::req_type     slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CntW-1:0]      used_ff, used_in;
   logic                 push;

   // idle items carry nothing and are dropped here
   assign req_stall = (used_ff == CntW'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall &&
                      (req_data.byte_valid || req_data.last_byte);
   assign q_valid   = (used_ff != '0);
   assign q_data    = slot_ff[head_ff];

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      used_in = used_ff;
      if (push) begin
         tail_in = (tail_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (q_pop && q_valid) begin
         head_in = (head_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      used_in = used_ff + CntW'(push) - CntW'(q_pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         used_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         used_ff <= used_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= req_data;
      end
   end

endmodule

[design/shs_core.sv]
module shs_core (
   input  logic                  clock,
   input  logic                  reset,
   input  shs_pkg::core_ctl_type ctl,
   input  logic [511:0]          block,
   output shs_pkg::core_sts_type sts,
   output logic [7:0][31:0]      chain
);

   shs_pkg::core_state_type state_ff, state_in;
   logic [7:0][31:0]  chain_ff;
   logic [7:0][31:0]  v_ff;
   logic [15:0][31:0] w_ff;
   logic [5:0]        round_ff;
   logic [31:0]       s1, ch, t1, s0, maj, t2, sg0, sg1, w_new;

   assign chain    = chain_ff;
   assign sts.busy = (state_ff != shs_pkg::CORE_IDLE);
   assign sts.done = (state_ff == shs_pkg::CORE_FIN);

   always_comb begin
      s1  = shs_pkg::ror(v_ff[4], 6) ^ shs_pkg::ror(v_ff[4], 11) ^ shs_pkg::ror(v_ff[4], 25);
      ch  = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1  = v_ff[7] + s1 + ch + shs_pkg::round_k(round_ff) + w_ff[0];
      s0  = shs_pkg::ror(v_ff[0], 2) ^ shs_pkg::ror(v_ff[0], 13) ^ shs_pkg::ror(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2  = s0 + maj;
      sg0 = shs_pkg::ror(w_ff[1], 7) ^ shs_pkg::ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      sg1 = shs_pkg::ror(w_ff[14], 17) ^ shs_pkg::ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + sg0 + w_ff[9] + sg1;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         shs_pkg::CORE_IDLE: if (ctl.start) state_in = shs_pkg::CORE_RUN;
         shs_pkg::CORE_RUN:  if (round_ff == 6'd63) state_in = shs_pkg::CORE_FIN;
         shs_pkg::CORE_FIN:  state_in = shs_pkg::CORE_IDLE;
         default:            state_in = shs_pkg::CORE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= shs_pkg::CORE_IDLE;
         round_ff <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= shs_pkg::init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         if (ctl.init) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= shs_pkg::init_hash(3'(i));
         end else if (state_ff == shs_pkg::CORE_FIN) begin
            for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
         end
         if (state_ff == shs_pkg::CORE_RUN) round_ff <= round_ff + 1'b1;
         else round_ff <= '0;
      end
      if (state_ff == shs_pkg::CORE_IDLE && ctl.start) begin
         v_ff <= chain_ff;
         for (int i = 0; i < 16; i++) w_ff[i] <= block[511 - 32*i -: 32];
      end else if (state_ff == shs_pkg::CORE_RUN) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

endmodule

[design/shs_back.sv]
module shs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  shs_pkg::req_type q_data,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shs_pkg::rsp_type rsp_data
);

   shs_pkg::back_state_type state_ff, state_in, resume_ff, resume_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  count_ff, count_in;
   logic [63:0]  len_ff, len_in;
   logic [511:0] blk_ff;
   logic         wait_ff, wait_in;
   logic         rsp_valid_ff, rsp_valid_in;
   shs_pkg::rsp_type rsp_ff;
   logic         push;
   logic [7:0]   push_byte;
   logic         load_rsp;
   shs_pkg::back_state_type after_push;
   shs_pkg::core_ctl_type ctl;
   shs_pkg::core_sts_type sts;
   logic [7:0][31:0] chain;

   shs_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .block (blk_ff),
      .sts   (sts),
      .chain (chain)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      resume_in    = resume_ff;
      fill_in      = fill_ff;
      count_in     = count_ff;
      len_in       = len_ff;
      wait_in      = wait_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      push         = 1'b0;
      push_byte    = q_data.data_byte;
      after_push   = state_ff;
      q_pop        = 1'b0;
      load_rsp     = 1'b0;
      ctl.start    = 1'b0;
      ctl.init     = 1'b0;
      unique case (state_ff)
         shs_pkg::ST_IDLE: if (q_valid) begin
            q_pop      = 1'b1;
            push       = q_data.byte_valid;
            count_in   = count_ff + 61'(q_data.byte_valid);
            len_in     = {count_in, 3'b000};
            after_push = q_data.last_byte ? shs_pkg::ST_PAD_ONE : shs_pkg::ST_IDLE;
            state_in   = after_push;
         end
         shs_pkg::ST_PAD_ONE: begin
            push       = 1'b1;
            push_byte  = shs_pkg::PAD_MARK;
            after_push = shs_pkg::ST_PAD_ZERO;
            state_in   = after_push;
         end
         shs_pkg::ST_PAD_ZERO: begin
            if (fill_ff == 6'(shs_pkg::LEN_FILL)) begin
               state_in = shs_pkg::ST_PAD_LEN;
            end else begin
               push      = 1'b1;
               push_byte = '0;
               after_push = shs_pkg::ST_PAD_ZERO;
            end
         end
         shs_pkg::ST_PAD_LEN: begin
            push       = 1'b1;
            push_byte  = len_ff[63:56];
            len_in     = {len_ff[55:0], 8'h00};
            after_push = shs_pkg::ST_OUT;
         end
         shs_pkg::ST_COMP: begin
            if (!wait_ff && !sts.busy) begin
               ctl.start = 1'b1;
               wait_in   = 1'b1;
            end else if (sts.done) begin
               wait_in  = 1'b0;
               state_in = resume_ff;
            end
         end
         shs_pkg::ST_OUT: if (!rsp_valid_ff || !rsp_stall) begin
            load_rsp     = 1'b1;
            rsp_valid_in = 1'b1;
            ctl.init     = 1'b1;
            count_in     = '0;
            state_in     = shs_pkg::ST_IDLE;
         end
         default: state_in = shs_pkg::ST_IDLE;
      endcase
      // a full block goes to the round engine, then the flow resumes
      if (push) begin
         fill_in = fill_ff + 1'b1;
         if (fill_ff == 6'(shs_pkg::BLOCK_BYTES - 1)) begin
            state_in  = shs_pkg::ST_COMP;
            resume_in = after_push;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= shs_pkg::ST_IDLE;
         resume_ff    <= shs_pkg::ST_IDLE;
         fill_ff      <= '0;
         count_ff     <= '0;
         wait_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         resume_ff    <= resume_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff <= len_in;
      if (push) blk_ff <= {blk_ff[503:0], push_byte};
      if (load_rsp) begin
         rsp_ff.digest_word_0 <= chain[0];
         rsp_ff.digest_word_1 <= chain[1];
         rsp_ff.digest_word_2 <= chain[2];
         rsp_ff.digest_word_3 <= chain[3];
         rsp_ff.digest_word_4 <= chain[4];
         rsp_ff.digest_word_5 <= chain[5];
         rsp_ff.digest_word_6 <= chain[6];
         rsp_ff.digest_word_7 <= chain[7];
      end
   end

endmodule
